// ----- design/rhc_pkg.sv -----
// Package for the RGB to HSV converter: pipeline work types, sector codes
// and fixed-point constants. No dependencies.
`default_nettype none

package rhc_pkg;

   // Number of restoring division steps; each divider cell resolves one quotient bit.
   localparam int RHC_DIV_STEPS = 12;
   localparam int RHC_NUM_W     = 20;
   localparam int RHC_QUO_W     = RHC_DIV_STEPS;
   localparam int RHC_HUE_W     = 15;

   localparam logic [RHC_NUM_W-1:0] RHC_SAT_SCALE = 20'd255;
   localparam logic [RHC_NUM_W-1:0] RHC_HUE_SCALE = 20'd3840;
   localparam logic [RHC_HUE_W-1:0] RHC_HUE_SIXTH = 15'd3840;
   localparam logic [RHC_HUE_W-1:0] RHC_HUE_TURN  = 15'd23040;

   typedef enum logic [1:0] {
      RHC_SECTOR_RED,
      RHC_SECTOR_GREEN,
      RHC_SECTOR_BLUE
   } rhc_sector_type;

   typedef struct packed {
      logic [7:0]           rem;
      logic [RHC_QUO_W-1:0] num;
      logic [RHC_QUO_W-1:0] quo;
      logic [7:0]           den;
   } rhc_div_type;

   typedef struct packed {
      rhc_div_type    hue_div;
      rhc_div_type    sat_div;
      rhc_sector_type sector;
      logic           negative;
      logic           black;
      logic           grey;
      logic [7:0]     brightness;
   } rhc_work_type;

endpackage

`default_nettype wire

// ----- design/rhc_if.sv -----
// Valid/ready channel interfaces for the RGB to HSV converter.
// Depends on nothing; the converter top level uses both.
`default_nettype none

interface rhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] hue;
   logic [7:0]  saturation;
   logic [7:0]  brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

`default_nettype wire

// ----- design/rhc_front.sv -----
// Front cell of the converter: finds max, min, span and hue sector and
// loads both divider numerators. Depends on rhc_pkg.
`default_nettype none

module rhc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [7:0]            red,
   input  wire logic [7:0]            green,
   input  wire logic [7:0]            blue,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output rhc_pkg::rhc_work_type      out_work
);

   logic                  valid_ff;
   rhc_pkg::rhc_work_type work_ff;
   rhc_pkg::rhc_work_type work_in;

   logic [7:0]                     max_val;
   logic [7:0]                     min_val;
   logic [7:0]                     span;
   logic [7:0]                     term_a;
   logic [7:0]                     term_b;
   logic [7:0]                     mag;
   logic [rhc_pkg::RHC_NUM_W-1:0] hue_num;
   logic [rhc_pkg::RHC_NUM_W-1:0] sat_num;
   rhc_pkg::rhc_sector_type        sector;

   always_comb begin
      max_val = red;
      if (green > max_val) max_val = green;
      if (blue > max_val) max_val = blue;
      min_val = red;
      if (green < min_val) min_val = green;
      if (blue < min_val) min_val = blue;
      span = max_val - min_val;

      // Ties for the largest component go to red first, then green.
      priority if (red >= max_val) begin
         sector = rhc_pkg::RHC_SECTOR_RED;
         term_a = green;
         term_b = blue;
      end else if (green >= max_val) begin
         sector = rhc_pkg::RHC_SECTOR_GREEN;
         term_a = blue;
         term_b = red;
      end else begin
         sector = rhc_pkg::RHC_SECTOR_BLUE;
         term_a = red;
         term_b = green;
      end
      mag = (term_a < term_b) ? (term_b - term_a) : (term_a - term_b);

      hue_num = {12'd0, mag} * rhc_pkg::RHC_HUE_SCALE;
      sat_num = {12'd0, span} * rhc_pkg::RHC_SAT_SCALE;

      // Both quotients stay below 4096, so the top byte is already below the divisor.
      work_in.hue_div.rem = hue_num[rhc_pkg::RHC_NUM_W-1:rhc_pkg::RHC_QUO_W];
      work_in.hue_div.num = hue_num[rhc_pkg::RHC_QUO_W-1:0];
      work_in.hue_div.quo = '0;
      work_in.hue_div.den = span;
      work_in.sat_div.rem = sat_num[rhc_pkg::RHC_NUM_W-1:rhc_pkg::RHC_QUO_W];
      work_in.sat_div.num = sat_num[rhc_pkg::RHC_QUO_W-1:0];
      work_in.sat_div.quo = '0;
      work_in.sat_div.den = max_val;
      work_in.sector      = sector;
      work_in.negative    = (term_a < term_b);
      work_in.black       = (max_val == 8'd0);
      work_in.grey        = (span == 8'd0);
      work_in.brightness  = max_val;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/rhc_div_cell.sv -----
// One divider cell: a single restoring step for both the hue and the
// saturation quotient, with a pipeline register. Depends on rhc_pkg.
`default_nettype none

module rhc_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rhc_pkg::rhc_work_type in_work,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output rhc_pkg::rhc_work_type      out_work
);

   logic                  valid_ff;
   rhc_pkg::rhc_work_type work_ff;
   rhc_pkg::rhc_work_type work_in;

   function automatic rhc_pkg::rhc_div_type div_step(input rhc_pkg::rhc_div_type d);
      rhc_pkg::rhc_div_type r;
      logic [8:0]           trial;
      logic                 fits;
      trial = {d.rem, d.num[rhc_pkg::RHC_QUO_W-1]};
      fits  = (trial >= {1'b0, d.den});
      r.rem = fits ? 8'(trial - {1'b0, d.den}) : trial[7:0];
      r.num = {d.num[rhc_pkg::RHC_QUO_W-2:0], 1'b0};
      r.quo = {d.quo[rhc_pkg::RHC_QUO_W-2:0], fits};
      r.den = d.den;
      return r;
   endfunction

   always_comb begin
      work_in         = in_work;
      work_in.hue_div = div_step(in_work.hue_div);
      work_in.sat_div = div_step(in_work.sat_div);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/rhc_back.sv -----
// Back cell of the converter: adds the hue quotient to or subtracts it from the
// sector offset, applies the black and grey cases and holds the result. Depends on rhc_pkg.
`default_nettype none

module rhc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rhc_pkg::rhc_work_type in_work,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [14:0]                hue,
   output logic [7:0]                 saturation,
   output logic [7:0]                 brightness
);

   logic        valid_ff;
   logic [14:0] hue_ff;
   logic [14:0] hue_in;
   logic [7:0]  saturation_ff;
   logic [7:0]  saturation_in;
   logic [7:0]  brightness_ff;
   logic [14:0] base;
   logic [14:0] quo;

   always_comb begin
      unique case (in_work.sector)
         rhc_pkg::RHC_SECTOR_RED:   base = '0;
         rhc_pkg::RHC_SECTOR_GREEN: base = rhc_pkg::RHC_HUE_SIXTH << 1;
         rhc_pkg::RHC_SECTOR_BLUE:  base = rhc_pkg::RHC_HUE_SIXTH << 2;
         default:                   base = '0;
      endcase
      quo = {3'd0, in_work.hue_div.quo};

      // Only the red sector can go below zero; it then wraps by a full turn.
      if (!in_work.negative) begin
         hue_in = base + quo;
      end else if (in_work.sector != rhc_pkg::RHC_SECTOR_RED) begin
         hue_in = base - quo;
      end else if (quo == '0) begin
         hue_in = '0;
      end else begin
         hue_in = rhc_pkg::RHC_HUE_TURN - quo;
      end
      if (in_work.black || in_work.grey) begin
         hue_in = '0;
      end
      saturation_in = in_work.black ? 8'd0 : in_work.sat_div.quo[7:0];
   end

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = saturation_ff;
   assign brightness = brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hue_ff        <= hue_in;
         saturation_ff <= saturation_in;
         brightness_ff <= in_work.brightness;
      end
   end

endmodule

`default_nettype wire

// ----- design/rgb_to_hsv_converter.sv -----
// RGB to HSV converter top level: front cell, a row of divider cells and
// the output cell. Depends on rhc_pkg, rhc_if, rhc_front, rhc_div_cell, rhc_back.
//
// Usage:
//   req_chan carries one pixel (red, green, blue, 8 bits each) per transaction.
//   rsp_chan returns one result per pixel, in order: hue in 1/64 degree
//   (0..23039), saturation (255 is full) and brightness (the largest component).
//   A transaction on either channel happens when valid and ready are both high.
//   From acceptance to rsp_chan.valid a pixel passes the front cell, which
//   registers it at the accepting edge, then twelve divider cells (one
//   quotient bit of each divider per cell) and the output register.
//   Throughput is one pixel per clock; every cell holds its own
//   transaction, so a new pixel enters in each cycle while the row flows.
//   When the receiver stalls, the held result stays on rsp_chan and the cells
//   behind it keep filling empty slots; req_chan.ready falls only once every
//   cell is occupied. Synchronous reset empties all cells; only the valid flags
//   are reset, and the block needs no settling time after reset.
`default_nettype none

module rgb_to_hsv_converter (
   input  wire logic clock,
   input  wire logic reset,
   rhc_req_if.sink   req_chan,
   rhc_rsp_if.source rsp_chan
);

   localparam int NUM_STAGES = rhc_pkg::RHC_DIV_STEPS + 1;

   logic                  stage_valid [NUM_STAGES];
   logic                  stage_ready [NUM_STAGES];
   rhc_pkg::rhc_work_type stage_work  [NUM_STAGES];

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .red       (req_chan.red),
      .green     (req_chan.green),
      .blue      (req_chan.blue),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_work  (stage_work[0])
   );

   for (genvar i = 0; i < rhc_pkg::RHC_DIV_STEPS; i++) begin : g_cell
      rhc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_work   (stage_work[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_work  (stage_work[i+1])
      );
   end

   rhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid[NUM_STAGES-1]),
      .in_ready   (stage_ready[NUM_STAGES-1]),
      .in_work    (stage_work[NUM_STAGES-1]),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .hue        (rsp_chan.hue),
      .saturation (rsp_chan.saturation),
      .brightness (rsp_chan.brightness)
   );

endmodule

`default_nettype wire
